### rtl/buddy_page_allocator_assert.svh
// Assertion macros for the buddy page allocator.
// Used by the top level; expects clk and rst_n in scope.
`ifndef BUDDY_PAGE_ALLOCATOR_ASSERT_SVH
`define BUDDY_PAGE_ALLOCATOR_ASSERT_SVH

`ifndef ASSERT_OFF
// property holds at every clock edge out of reset
`define BPA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// consequent holds in the cycle after the antecedent
`define BPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BPA_ASSERT(label, prop, msg)
`define BPA_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

### rtl/bpa_pkg.sv
// Shared types, codes and helpers of the buddy page allocator.
// No dependencies.
`timescale 1ns / 1ps
package bpa_pkg;

    localparam int MAX_RANK      = 16;
    localparam int DEF_MAX_PAGES = 65536;
    localparam int PAGE_SHIFT    = 12;      // 4096-byte pages
    localparam int OFS_W         = 28;
    localparam int RANK_W        = 5;
    localparam int PG_W          = 17;      // page index plus the empty mark
    localparam int RIDX_W        = $clog2(MAX_RANK);

    localparam logic [1:0] FN_ALLOC  = 2'd0;
    localparam logic [1:0] FN_FREE   = 2'd1;
    localparam logic [1:0] FN_QRANK  = 2'd2;
    localparam logic [1:0] FN_QCOUNT = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVAL   = 2'd1;
    localparam logic [1:0] ST_NOSPACE = 2'd2;

    typedef logic [PG_W-1:0] page_t;

    // page store entry: allocated rank, or free-block head mark with its rank
    typedef struct packed {
        logic              free;
        logic [RANK_W-1:0] rank;
    } tag_t;

    typedef struct packed {
        page_t next;
        page_t prev;
    } link_t;

    typedef struct packed {
        logic  we;
        logic  re;
        page_t addr;
        tag_t  wdata;
    } pm_req_t;

    typedef struct packed {
        logic  re;
        logic  we_next;
        logic  we_prev;
        page_t addr;
        link_t wdata;
    } lm_req_t;

    function automatic page_t blk_size(input logic [RANK_W-1:0] r);
        return page_t'(1) << (r - 1'b1);
    endfunction

endpackage

### rtl/bpa_page_mem.sv
// Page store: one tag per page, one write and one registered read port.
// Depends on bpa_pkg.
`timescale 1ns / 1ps
module bpa_page_mem #(
    parameter int MAX_PAGES = bpa_pkg::DEF_MAX_PAGES
) (
    input  logic              clk,
    input  bpa_pkg::pm_req_t  req,
    output bpa_pkg::tag_t     rdata
);
    import bpa_pkg::*;

    localparam int AW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;

    tag_t mem [MAX_PAGES];
    tag_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr[AW-1:0]] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.addr[AW-1:0]];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/bpa_link_mem.sv
// Free-list link store: next/prev per block head, field write enables.
// Depends on bpa_pkg.
`timescale 1ns / 1ps
module bpa_link_mem #(
    parameter int MAX_PAGES = bpa_pkg::DEF_MAX_PAGES
) (
    input  logic              clk,
    input  bpa_pkg::lm_req_t  req,
    output bpa_pkg::link_t    rdata
);
    import bpa_pkg::*;

    localparam int AW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;

    link_t mem [MAX_PAGES];
    link_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we_next)
        begin
            mem[req.addr[AW-1:0]].next <= req.wdata.next;
        end
        if (req.we_prev)
        begin
            mem[req.addr[AW-1:0]].prev <= req.wdata.prev;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.addr[AW-1:0]];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/bpa_ctrl.sv
// Allocator sequencer: list heads and counts, clear/seed, operations.
// Depends on bpa_pkg; drives bpa_page_mem and bpa_link_mem.
`timescale 1ns / 1ps
module bpa_ctrl #(
    parameter int MAX_PAGES = bpa_pkg::DEF_MAX_PAGES
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [1:0]                  func,
    input  logic [bpa_pkg::RANK_W-1:0]  req_rank,
    input  logic [bpa_pkg::OFS_W-1:0]   byte_offset,
    input  bpa_pkg::page_t              pool,
    input  logic                        cfg_wr,
    output logic                        busy,
    output logic                        done,
    output logic [1:0]                  status,
    output logic [15:0]                 block_page,
    output logic [16:0]                 answer,
    output bpa_pkg::pm_req_t            pm_req,
    input  bpa_pkg::tag_t               pm_rdata,
    output bpa_pkg::lm_req_t            lm_req,
    input  bpa_pkg::link_t              lm_rdata
);
    import bpa_pkg::*;

    localparam page_t NIL  = PG_W'(MAX_PAGES);
    localparam page_t LAST = PG_W'(MAX_PAGES - 1);

    typedef enum logic [17:0] {
        S_CLR     = 18'b000000000000000001,
        S_SEED    = 18'b000000000000000010,
        S_IDLE    = 18'b000000000000000100,
        S_DISP    = 18'b000000000000001000,
        S_A_POP   = 18'b000000000000010000,
        S_A_SPLIT = 18'b000000000000100000,
        S_A_FILL  = 18'b000000000001000000,
        S_R_CHK   = 18'b000000000010000000,
        S_R_CLR   = 18'b000000000100000000,
        S_R_MRG   = 18'b000000001000000000,
        S_R_BUD   = 18'b000000010000000000,
        S_R_UNL   = 18'b000000100000000000,
        S_R_UNL2  = 18'b000001000000000000,
        S_Q_CHK   = 18'b000010000000000000,
        S_Q_SCAN  = 18'b000100000000000000,
        S_PUSH0   = 18'b001000000000000000,
        S_PUSH1   = 18'b010000000000000000,
        S_FIN     = 18'b100000000000000000
    } state_t;

    state_t             state_reg, state_next, ret_reg, ret_next;
    logic [1:0]         func_reg, func_next;
    logic [RANK_W-1:0]  req_reg, req_next, r_reg, r_next;
    logic [RANK_W-1:0]  push_rank_reg, push_rank_next;
    logic               ofs_ok_reg, ofs_ok_next;
    page_t              pg_reg, pg_next, cnt_reg, cnt_next, bud_reg, bud_next;
    page_t              push_page_reg, push_page_next, old_head_reg, old_head_next;
    page_t              nxt_reg, nxt_next, prv_reg, prv_next;
    page_t              heads_reg [MAX_RANK];
    page_t              heads_next [MAX_RANK];
    page_t              counts_reg [MAX_RANK];
    page_t              counts_next [MAX_RANK];
    logic               done_reg, done_next;
    logic [1:0]         status_reg, status_next;
    logic [15:0]        bpage_reg, bpage_next;
    logic [16:0]        answer_reg, answer_next;

    logic               found_hit;
    logic [RIDX_W-1:0]  found_idx, list_idx;
    logic [RANK_W-1:0]  seed_rank;
    page_t              head_rd, cnt_rd;

    // lowest non-empty rank at or above the request
    always_comb
    begin
        found_hit = 1'b0;
        found_idx = '0;
        for (int i = MAX_RANK - 1; i >= 0; i--)
        begin
            if (counts_reg[i] != '0 && (RANK_W'(i) + 1'b1) >= req_reg)
            begin
                found_hit = 1'b1;
                found_idx = RIDX_W'(i);
            end
        end
    end

    // largest aligned block at the seed cursor that fits in the pool
    always_comb
    begin
        seed_rank = RANK_W'(1);
        for (int i = 1; i <= MAX_RANK; i++)
        begin
            if ((pg_reg & (blk_size(RANK_W'(i)) - 1'b1)) == '0 &&
                ({1'b0, pg_reg} + {1'b0, blk_size(RANK_W'(i))}) <= {1'b0, pool})
            begin
                seed_rank = RANK_W'(i);
            end
        end
    end

    // single list-table port
    always_comb
    begin
        list_idx = '0;
        unique case (state_reg) inside
            S_DISP:
            begin
                if (func_reg == FN_ALLOC) list_idx = found_idx;
                else                      list_idx = RIDX_W'(req_reg - 1'b1);
            end
            S_A_POP, S_R_UNL: list_idx = RIDX_W'(r_reg - 1'b1);
            S_PUSH0:          list_idx = RIDX_W'(push_rank_reg - 1'b1);
            default:          list_idx = '0;
        endcase
    end

    assign head_rd = heads_reg[list_idx];
    assign cnt_rd  = counts_reg[list_idx];

    always_comb
    begin
        tag_t  e;
        link_t l;
        page_t s;
        page_t bud;
        logic  rbad;

        state_next     = state_reg;
        ret_next       = ret_reg;
        func_next      = func_reg;
        req_next       = req_reg;
        r_next         = r_reg;
        push_rank_next = push_rank_reg;
        ofs_ok_next    = ofs_ok_reg;
        pg_next        = pg_reg;
        cnt_next       = cnt_reg;
        bud_next       = bud_reg;
        push_page_next = push_page_reg;
        old_head_next  = old_head_reg;
        nxt_next       = nxt_reg;
        prv_next       = prv_reg;
        heads_next     = heads_reg;
        counts_next    = counts_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        bpage_next     = bpage_reg;
        answer_next    = answer_reg;
        pm_req         = '0;
        lm_req         = '0;
        e              = pm_rdata;
        l              = lm_rdata;
        s              = blk_size(r_reg);
        bud            = pg_reg ^ s;
        rbad           = (req_reg == '0) || (req_reg > RANK_W'(MAX_RANK));

        unique case (state_reg)
            S_CLR:
            begin
                pm_req.we    = 1'b1;
                pm_req.addr  = cnt_reg;
                pm_req.wdata = '0;
                for (int i = 0; i < MAX_RANK; i++)
                begin
                    heads_next[i]  = NIL;
                    counts_next[i] = '0;
                end
                if (cnt_reg == LAST)
                begin
                    pg_next    = '0;
                    state_next = S_SEED;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            S_SEED:
            begin
                if (pg_reg < pool)
                begin
                    push_rank_next = seed_rank;
                    push_page_next = pg_reg;
                    pg_next        = pg_reg + blk_size(seed_rank);
                    ret_next       = S_SEED;
                    state_next     = S_PUSH0;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    func_next   = func;
                    req_next    = req_rank;
                    pg_next     = PG_W'(byte_offset[OFS_W-1:PAGE_SHIFT]);
                    ofs_ok_next = (byte_offset[PAGE_SHIFT-1:0] == '0) &&
                                  (PG_W'(byte_offset[OFS_W-1:PAGE_SHIFT]) < pool);
                    status_next = ST_OK;
                    bpage_next  = '0;
                    answer_next = '0;
                    state_next  = S_DISP;
                end
            end

            S_DISP:
            begin
                case (func_reg) inside
                    FN_ALLOC:
                    begin
                        if (rbad)
                        begin
                            status_next = ST_INVAL;
                            state_next  = S_FIN;
                        end
                        else if (!found_hit)
                        begin
                            status_next = ST_NOSPACE;
                            state_next  = S_FIN;
                        end
                        else
                        begin
                            pg_next               = head_rd;
                            r_next                = RANK_W'(found_idx) + 1'b1;
                            counts_next[list_idx] = cnt_rd - 1'b1;
                            lm_req.re             = 1'b1;
                            lm_req.addr           = head_rd;
                            state_next            = S_A_POP;
                        end
                    end
                    FN_FREE, FN_QRANK:
                    begin
                        if (!ofs_ok_reg)
                        begin
                            status_next = ST_INVAL;
                            state_next  = S_FIN;
                        end
                        else
                        begin
                            pm_req.re   = 1'b1;
                            pm_req.addr = pg_reg;
                            state_next  = (func_reg == FN_FREE) ? S_R_CHK : S_Q_CHK;
                        end
                    end
                    default:
                    begin
                        if (rbad) status_next = ST_INVAL;
                        else      answer_next = cnt_rd;
                        state_next = S_FIN;
                    end
                endcase
            end

            S_A_POP:
            begin
                heads_next[list_idx] = l.next;
                if (l.next != NIL)
                begin
                    lm_req.we_prev    = 1'b1;
                    lm_req.addr       = l.next;
                    lm_req.wdata.prev = NIL;
                end
                state_next = S_A_SPLIT;
            end

            S_A_SPLIT:
            begin
                if (r_reg > req_reg)
                begin
                    r_next         = r_reg - 1'b1;
                    push_rank_next = r_reg - 1'b1;
                    push_page_next = pg_reg + blk_size(r_reg - 1'b1);
                    ret_next       = S_A_SPLIT;
                    state_next     = S_PUSH0;
                end
                else
                begin
                    cnt_next   = '0;
                    state_next = S_A_FILL;
                end
            end

            S_A_FILL:
            begin
                pm_req.we         = 1'b1;
                pm_req.addr       = pg_reg + cnt_reg;
                pm_req.wdata.free = 1'b0;
                pm_req.wdata.rank = req_reg;
                if (cnt_reg == blk_size(req_reg) - 1'b1)
                begin
                    bpage_next = pg_reg[15:0];
                    state_next = S_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            S_R_CHK:
            begin
                if (e.free || e.rank == '0 || e.rank > RANK_W'(MAX_RANK) ||
                    (pg_reg & (blk_size(e.rank) - 1'b1)) != '0)
                begin
                    status_next = ST_INVAL;
                    state_next  = S_FIN;
                end
                else
                begin
                    r_next     = e.rank;
                    cnt_next   = '0;
                    state_next = S_R_CLR;
                end
            end

            S_R_CLR:
            begin
                pm_req.we    = 1'b1;
                pm_req.addr  = pg_reg + cnt_reg;
                pm_req.wdata = '0;
                if (cnt_reg == s - 1'b1) state_next = S_R_MRG;
                else                     cnt_next   = cnt_reg + 1'b1;
            end

            S_R_MRG:
            begin
                if (r_reg < RANK_W'(MAX_RANK) &&
                    ({1'b0, bud} + {1'b0, s}) <= {1'b0, pool})
                begin
                    bud_next    = bud;
                    pm_req.re   = 1'b1;
                    pm_req.addr = bud;
                    state_next  = S_R_BUD;
                end
                else
                begin
                    push_rank_next = r_reg;
                    push_page_next = pg_reg;
                    ret_next       = S_FIN;
                    state_next     = S_PUSH0;
                end
            end

            S_R_BUD:
            begin
                if (e.free && e.rank == r_reg)
                begin
                    pm_req.we    = 1'b1;
                    pm_req.addr  = bud_reg;
                    pm_req.wdata = '0;
                    lm_req.re    = 1'b1;
                    lm_req.addr  = bud_reg;
                    state_next   = S_R_UNL;
                end
                else
                begin
                    push_rank_next = r_reg;
                    push_page_next = pg_reg;
                    ret_next       = S_FIN;
                    state_next     = S_PUSH0;
                end
            end

            S_R_UNL:
            begin
                nxt_next              = l.next;
                prv_next              = l.prev;
                counts_next[list_idx] = cnt_rd - 1'b1;
                if (l.prev == NIL)
                begin
                    heads_next[list_idx] = l.next;
                end
                else
                begin
                    lm_req.we_next    = 1'b1;
                    lm_req.addr       = l.prev;
                    lm_req.wdata.next = l.next;
                end
                if (l.next != NIL)
                begin
                    state_next = S_R_UNL2;
                end
                else
                begin
                    pg_next    = (bud_reg < pg_reg) ? bud_reg : pg_reg;
                    r_next     = r_reg + 1'b1;
                    state_next = S_R_MRG;
                end
            end

            S_R_UNL2:
            begin
                lm_req.we_prev    = 1'b1;
                lm_req.addr       = nxt_reg;
                lm_req.wdata.prev = prv_reg;
                pg_next           = (bud_reg < pg_reg) ? bud_reg : pg_reg;
                r_next            = r_reg + 1'b1;
                state_next        = S_R_MRG;
            end

            S_Q_CHK:
            begin
                if (!e.free && e.rank != '0)
                begin
                    answer_next = 17'(e.rank);
                    state_next  = S_FIN;
                end
                else
                begin
                    r_next      = RANK_W'(MAX_RANK);
                    pm_req.re   = 1'b1;
                    pm_req.addr = pg_reg & ~(blk_size(RANK_W'(MAX_RANK)) - 1'b1);
                    state_next  = S_Q_SCAN;
                end
            end

            S_Q_SCAN:
            begin
                if (e.free && e.rank == r_reg)
                begin
                    answer_next = 17'(r_reg);
                    state_next  = S_FIN;
                end
                else if (r_reg == RANK_W'(1))
                begin
                    status_next = ST_INVAL;
                    state_next  = S_FIN;
                end
                else
                begin
                    r_next      = r_reg - 1'b1;
                    pm_req.re   = 1'b1;
                    pm_req.addr = pg_reg & ~(blk_size(r_reg - 1'b1) - 1'b1);
                end
            end

            S_PUSH0:
            begin
                lm_req.we_next        = 1'b1;
                lm_req.we_prev        = 1'b1;
                lm_req.addr           = push_page_reg;
                lm_req.wdata.next     = head_rd;
                lm_req.wdata.prev     = NIL;
                pm_req.we             = 1'b1;
                pm_req.addr           = push_page_reg;
                pm_req.wdata.free     = 1'b1;
                pm_req.wdata.rank     = push_rank_reg;
                heads_next[list_idx]  = push_page_reg;
                counts_next[list_idx] = cnt_rd + 1'b1;
                old_head_next         = head_rd;
                state_next            = (head_rd != NIL) ? S_PUSH1 : ret_reg;
            end

            S_PUSH1:
            begin
                lm_req.we_prev    = 1'b1;
                lm_req.addr       = old_head_reg;
                lm_req.wdata.prev = push_page_reg;
                state_next        = ret_reg;
            end

            S_FIN:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // a pool write restarts the clear pass
        if (cfg_wr)
        begin
            cnt_next   = '0;
            done_next  = 1'b0;
            state_next = S_CLR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            ret_reg   <= S_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            for (int i = 0; i < MAX_RANK; i++)
            begin
                heads_reg[i]  <= NIL;
                counts_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            cnt_reg    <= cnt_next;
            done_reg   <= done_next;
            heads_reg  <= heads_next;
            counts_reg <= counts_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        req_reg       <= req_next;
        r_reg         <= r_next;
        push_rank_reg <= push_rank_next;
        ofs_ok_reg    <= ofs_ok_next;
        pg_reg        <= pg_next;
        bud_reg       <= bud_next;
        push_page_reg <= push_page_next;
        old_head_reg  <= old_head_next;
        nxt_reg       <= nxt_next;
        prv_reg       <= prv_next;
        status_reg    <= status_next;
        bpage_reg     <= bpage_next;
        answer_reg    <= answer_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign status     = status_reg;
    assign block_page = bpage_reg;
    assign answer     = answer_reg;

endmodule

### rtl/buddy_page_allocator.sv
// Buddy page allocator top level: config port, pool register, memories.
// Depends on bpa_pkg, bpa_page_mem, bpa_link_mem, bpa_ctrl and the assert header.
//
// Usage:
//  - Command channel: a transaction is taken at a rising edge with start high
//    and busy low (func, req_rank, byte_offset). One result per transaction
//    appears on status/block_page/answer for exactly one cycle with done high.
//  - Allocate pops a free block, splits it down to the requested rank, then
//    stamps each page of the granted block; return checks and clears the
//    block's pages, then merges with a free buddy rank by rank; a rank query
//    does one page store read per rank probed, from the top rank down.
//    Pages of a block are stamped one per cycle through the single write
//    port, so large blocks take longest.
//  - The next transaction is taken in the cycle done is shown.
//  - Results cannot be held off; done is a one-cycle strobe.
//  - Config: APB-style, pool_pages at byte address 0, pready tied high.
//    Values of pwdata[16:0] above MAX_PAGES saturate; higher bits are ignored. A write rebuilds all state.
//  - Reset and each pool write run a clearing pass over all MAX_PAGES entries
//    of the page store, then seed the free lists; busy stays high throughout.
`timescale 1ns / 1ps
`include "buddy_page_allocator_assert.svh"
module buddy_page_allocator #(
    parameter int MAX_PAGES = bpa_pkg::DEF_MAX_PAGES
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // command channel
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  func,
    input  logic [bpa_pkg::RANK_W-1:0]  req_rank,
    input  logic [bpa_pkg::OFS_W-1:0]   byte_offset,
    // result channel
    output logic                        done,
    output logic [1:0]                  status,
    output logic [15:0]                 block_page,
    output logic [16:0]                 answer,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [1:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import bpa_pkg::*;

    page_t    pool_reg, pool_next;
    logic     cfg_wr;
    pm_req_t  pm_req;
    tag_t     pm_rdata;
    lm_req_t  lm_req;
    link_t    lm_rdata;

    // single register, so every byte address decodes to pool_pages
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = {15'b0, pool_reg};

    // saturate at the managed capacity
    always_comb
    begin
        pool_next = pool_reg;
        if (cfg_wr)
        begin
            if (pwdata[PG_W-1:0] > PG_W'(MAX_PAGES)) pool_next = PG_W'(MAX_PAGES);
            else                                     pool_next = pwdata[PG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_reg <= PG_W'(MAX_PAGES);
        end
        else
        begin
            pool_reg <= pool_next;
        end
    end

    bpa_ctrl #(
        .MAX_PAGES (MAX_PAGES)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .func        (func),
        .req_rank    (req_rank),
        .byte_offset (byte_offset),
        .pool        (pool_reg),
        .cfg_wr      (cfg_wr),
        .busy        (busy),
        .done        (done),
        .status      (status),
        .block_page  (block_page),
        .answer      (answer),
        .pm_req      (pm_req),
        .pm_rdata    (pm_rdata),
        .lm_req      (lm_req),
        .lm_rdata    (lm_rdata)
    );

    bpa_page_mem #(
        .MAX_PAGES (MAX_PAGES)
    ) u_page_mem (
        .clk   (clk),
        .req   (pm_req),
        .rdata (pm_rdata)
    );

    bpa_link_mem #(
        .MAX_PAGES (MAX_PAGES)
    ) u_link_mem (
        .clk   (clk),
        .req   (lm_req),
        .rdata (lm_rdata)
    );

    // a result only closes work that was in flight
    `BPA_ASSERT(a_done_after_busy, done |-> $past(busy), "done without a pending transaction")
    // an accepted command occupies the sequencer
    `BPA_ASSERT_NEXT(a_start_busy, start && !busy, busy, "command accepted but not busy")
    // a pool write always starts the rebuild
    `BPA_ASSERT_NEXT(a_cfg_busy, cfg_wr, busy && !done, "pool write did not start rebuild")
    // page field only carries a granted block
    `BPA_ASSERT(a_page_zero, (done && status != ST_OK) |-> (block_page == '0), "page on failure")

endmodule
